// ----- sv/lav_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lav_pkg
// Shared constants and types for the look-at view matrix core.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int unsigned WORD_W  = 32;  // field width of every coordinate
  localparam int unsigned VEC_N   = 3;
  localparam int unsigned MAN_W   = 31;  // normalised magnitude width
  localparam int unsigned MAN_TOP = 30;  // leading one lands here
  localparam int unsigned SUM_W   = 64;  // sum of squares
  localparam int unsigned ROOT_W  = 32;  // integer square root
  localparam int unsigned REM_W   = ROOT_W + 3;

  typedef logic [1:0] col_t;
  localparam col_t COL_FIRST = 2'd0;
  localparam col_t COL_LAST  = 2'd3;

  typedef struct packed {
    logic valid;
    logic zero;
  } nrm_flag_t;

endpackage
`default_nettype wire

// ----- sv/lav_norm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normaliser: block-float scale, square sum, one root bit
// and one quotient bit per stage. A sideband word travels with each request.
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int IN_W      = 33,
  parameter int FRAC_BITS = 16,
  parameter int SB_W      = 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic [2:0][IN_W-1:0]         in_vec,
  input  wire logic [SB_W-1:0]              in_sb,
  output lav_pkg::nrm_flag_t                out_flag,
  output logic      [2:0][FRAC_BITS+1:0]    out_vec,
  output logic      [SB_W-1:0]              out_sb
);

  localparam int MW        = lav_pkg::MAN_W;
  localparam int RW        = lav_pkg::ROOT_W;
  localparam int QW        = FRAC_BITS + 1;
  localparam int OW        = FRAC_BITS + 2;
  localparam int NUM_W     = MW + FRAC_BITS + 1;
  localparam int PW        = $clog2(IN_W);
  localparam int M_LO      = 0;
  localparam int NEG_LO    = 3 * MW;
  localparam int ZERO_BIT  = NEG_LO + 3;
  localparam int SB_LO     = ZERO_BIT + 1;
  localparam int CAR_W     = SB_LO + SB_W;

  // stage A: magnitudes
  logic                    a_v_r;
  logic [2:0][IN_W-1:0]    a_mag_r;
  logic [2:0]              a_neg_r;
  logic [SB_W-1:0]         a_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= in_valid;
    end
    for (int i = 0; i < 3; i++) begin
      a_neg_r[i] <= in_vec[i][IN_W-1];
      a_mag_r[i] <= in_vec[i][IN_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
    end
    a_sb_r <= in_sb;
  end

  // stage B: common shift
  logic [IN_W-1:0] b_hi;
  logic [PW-1:0]   b_pos;
  logic [2:0][MW-1:0] b_m_nxt;

  always_comb begin
    b_hi  = a_mag_r[0] | a_mag_r[1] | a_mag_r[2];
    b_pos = '0;
    for (int k = 0; k < IN_W; k++) begin
      if (b_hi[k]) begin
        b_pos = PW'(k);
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (b_pos >= PW'(lav_pkg::MAN_TOP)) begin
        b_m_nxt[i] = MW'(a_mag_r[i] >> (b_pos - PW'(lav_pkg::MAN_TOP)));
      end else begin
        b_m_nxt[i] = MW'(a_mag_r[i] << (PW'(lav_pkg::MAN_TOP) - b_pos));
      end
    end
  end

  logic               b_v_r;
  logic [2:0][MW-1:0] b_m_r;
  logic [2:0]         b_neg_r;
  logic               b_zero_r;
  logic [SB_W-1:0]    b_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r;
    end
    b_m_r    <= b_m_nxt;
    b_neg_r  <= a_neg_r;
    b_zero_r <= (b_hi == '0);
    b_sb_r   <= a_sb_r;
  end

  // stage C: squares
  logic                   c_v_r;
  logic [2:0][2*MW-1:0]   c_sq_r;
  logic [CAR_W-1:0]       c_car_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else begin
      c_v_r <= b_v_r;
    end
    for (int i = 0; i < 3; i++) begin
      c_sq_r[i] <= b_m_r[i] * b_m_r[i];
    end
    c_car_r <= {b_sb_r, b_zero_r, b_neg_r, b_m_r};
  end

  // square root, one result bit per stage
  logic                        isq_v_r    [0:RW];
  logic [lav_pkg::SUM_W-1:0]   isq_x_r    [0:RW];
  logic [lav_pkg::REM_W-1:0]   isq_rem_r  [0:RW];
  logic [RW-1:0]               isq_root_r [0:RW];
  logic [CAR_W-1:0]            isq_car_r  [0:RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      isq_v_r[0] <= 1'b0;
    end else begin
      isq_v_r[0] <= c_v_r;
    end
    isq_x_r[0]    <= lav_pkg::SUM_W'(c_sq_r[0]) + lav_pkg::SUM_W'(c_sq_r[1])
                   + lav_pkg::SUM_W'(c_sq_r[2]);
    isq_rem_r[0]  <= '0;
    isq_root_r[0] <= '0;
    isq_car_r[0]  <= c_car_r;
  end

  for (genvar k = 0; k < RW; k++) begin : g_isq
    logic [lav_pkg::REM_W-1:0] rem2;
    logic [lav_pkg::REM_W-1:0] trial;
    logic                      ge;

    always_comb begin
      rem2  = {isq_rem_r[k][lav_pkg::REM_W-3:0],
               isq_x_r[k][lav_pkg::SUM_W-1 -: 2]};
      trial = lav_pkg::REM_W'({isq_root_r[k], 2'b01});
      ge    = (rem2 >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        isq_v_r[k+1] <= 1'b0;
      end else begin
        isq_v_r[k+1] <= isq_v_r[k];
      end
      isq_x_r[k+1]    <= isq_x_r[k] << 2;
      isq_rem_r[k+1]  <= ge ? (rem2 - trial) : rem2;
      isq_root_r[k+1] <= {isq_root_r[k][RW-2:0], ge};
      isq_car_r[k+1]  <= isq_car_r[k];
    end
  end

  // division, one quotient bit per stage
  logic                   dv_v_r   [0:QW];
  logic [RW-1:0]          dv_len_r [0:QW];
  logic [2:0][NUM_W-1:0]  dv_n_r   [0:QW];
  logic [2:0][RW-1:0]     dv_rem_r [0:QW];
  logic [2:0][QW-1:0]     dv_q_r   [0:QW];
  logic [CAR_W-1:0]       dv_car_r [0:QW];

  logic [RW-1:0]          n_len;
  logic [2:0][MW-1:0]     n_m;
  logic [2:0][NUM_W-1:0]  n_num;

  always_comb begin
    n_len = isq_root_r[RW];
    n_m   = isq_car_r[RW][NEG_LO-1:M_LO];
    for (int i = 0; i < 3; i++) begin
      n_num[i] = (NUM_W'(n_m[i]) << FRAC_BITS) + NUM_W'(n_len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= isq_v_r[RW];
    end
    dv_len_r[0] <= n_len;
    dv_n_r[0]   <= n_num;
    for (int i = 0; i < 3; i++) begin
      dv_rem_r[0][i] <= RW'(n_num[i][NUM_W-1:QW]);
    end
    dv_q_r[0]   <= '0;
    dv_car_r[0] <= isq_car_r[RW];
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [2:0][RW:0]   r;
    logic [2:0]         ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r[i]  = {dv_rem_r[j][i], dv_n_r[j][i][FRAC_BITS-j]};
        ge[i] = (r[i] >= {1'b0, dv_len_r[j]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
      dv_len_r[j+1] <= dv_len_r[j];
      dv_n_r[j+1]   <= dv_n_r[j];
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[j+1][i] <= ge[i] ? RW'(r[i] - {1'b0, dv_len_r[j]}) : RW'(r[i]);
        dv_q_r[j+1][i]   <= {dv_q_r[j][i][QW-2:0], ge[i]};
      end
      dv_car_r[j+1] <= dv_car_r[j];
    end
  end

  // output: sign restored, zero vector forced to zero
  logic [2:0] o_neg;
  logic       o_zero;

  always_comb begin
    o_neg  = dv_car_r[QW][ZERO_BIT-1:NEG_LO];
    o_zero = dv_car_r[QW][ZERO_BIT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_flag.valid <= 1'b0;
    end else begin
      out_flag.valid <= dv_v_r[QW];
    end
    out_flag.zero <= o_zero;
    for (int i = 0; i < 3; i++) begin
      if (o_zero) begin
        out_vec[i] <= '0;
      end else if (o_neg[i]) begin
        out_vec[i] <= OW'(~{1'b0, dv_q_r[QW][i]} + 1'b1);
      end else begin
        out_vec[i] <= {1'b0, dv_q_r[QW][i]};
      end
    end
    out_sb <= dv_car_r[QW][CAR_W-1:SB_LO];
  end

endmodule
`default_nettype wire

// ----- sv/look_at_view_matrix_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// look_at_view_matrix_core
// Right-handed look-at view matrix in signed fixed point, four columns out.
// ----------------------------------------------------------------------------
// Output: column 0 appears first once the request has passed the pipeline;
//   columns 1 to 3 follow in order while out_valid stays high.
// Pacing: set by the four-column result port; busy is high after each
//   request, and a new request is taken only once busy has dropped.
// Reset: synchronous, clears all valid bits and the column sequencer.
module look_at_view_matrix_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_eye_x,
  input  wire logic signed [31:0] in_eye_y,
  input  wire logic signed [31:0] in_eye_z,
  input  wire logic signed [31:0] in_target_x,
  input  wire logic signed [31:0] in_target_y,
  input  wire logic signed [31:0] in_target_z,
  input  wire logic signed [31:0] in_up_x,
  input  wire logic signed [31:0] in_up_y,
  input  wire logic signed [31:0] in_up_z,
  output logic                    out_valid,
  output lav_pkg::col_t           out_column,
  output logic signed [31:0]      out_entry_0,
  output logic signed [31:0]      out_entry_1,
  output logic signed [31:0]      out_entry_2,
  output logic signed [31:0]      out_entry_3,
  output logic                    out_degenerate,
  output logic                    out_last
);

  localparam int WW    = lav_pkg::WORD_W;
  localparam int FW    = FRAC_BITS + 2;
  localparam int PW    = FW + WW;
  localparam int CW    = PW + 1;
  localparam int SW    = 2 * FW;
  localparam int UFW   = SW + 1;
  localparam int UW    = FRAC_BITS + 3;
  localparam int DW    = PW + 2;
  localparam int UPW   = UW + WW;
  localparam int UDW   = UPW + 2;
  localparam int SB1_W = 6 * WW;
  localparam int SB2_W = 3 * WW + 3 * FW + 1;
  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;

  function automatic logic signed [63:0] rnd_down(input logic signed [63:0] p);
    logic [63:0] m;
    m = p[63] ? 64'(-p) : 64'(p);
    m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return p[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > MAX32) begin
      return 32'sh7fffffff;
    end else if (v < MIN32) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // request pacing
  logic       acc;
  logic [1:0] gap_r;

  assign acc  = start && !busy;
  assign busy = (gap_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= 2'd0;
    end else if (acc) begin
      gap_r <= 2'd3;
    end else if (gap_r != 2'd0) begin
      gap_r <= gap_r - 2'd1;
    end
  end

  // input register
  logic                in_v_r;
  logic [2:0][WW-1:0]  eye_r;
  logic [2:0][WW-1:0]  tgt_r;
  logic [2:0][WW-1:0]  up_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= acc;
    end
    eye_r <= {in_eye_z, in_eye_y, in_eye_x};
    tgt_r <= {in_target_z, in_target_y, in_target_x};
    up_r  <= {in_up_z, in_up_y, in_up_x};
  end

  logic [2:0][WW:0] d_vec;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_vec[i] = {tgt_r[i][WW-1], tgt_r[i]} - {eye_r[i][WW-1], eye_r[i]};
    end
  end

  // forward vector
  lav_pkg::nrm_flag_t   n1_flag;
  logic [2:0][FW-1:0]   n1_vec;
  logic [SB1_W-1:0]     n1_sb;

  lav_norm #(
    .IN_W      (WW + 1),
    .FRAC_BITS (FRAC_BITS),
    .SB_W      (SB1_W)
  ) u_norm_f (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_v_r),
    .in_vec   (d_vec),
    .in_sb    ({eye_r, up_r}),
    .out_flag (n1_flag),
    .out_vec  (n1_vec),
    .out_sb   (n1_sb)
  );

  logic [2:0][WW-1:0] n1_eye;
  logic [2:0][WW-1:0] n1_up;

  assign n1_eye = n1_sb[SB1_W-1:3*WW];
  assign n1_up  = n1_sb[3*WW-1:0];

  // f x up products
  logic                 t1_v_r;
  logic signed [PW-1:0] t1_p_r [6];
  logic [2:0][FW-1:0]   t1_f_r;
  logic [2:0][WW-1:0]   t1_eye_r;
  logic                 t1_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
    end else begin
      t1_v_r <= n1_flag.valid;
    end
    t1_p_r[0] <= $signed(n1_vec[1]) * $signed(n1_up[2]);
    t1_p_r[1] <= $signed(n1_vec[2]) * $signed(n1_up[1]);
    t1_p_r[2] <= $signed(n1_vec[2]) * $signed(n1_up[0]);
    t1_p_r[3] <= $signed(n1_vec[0]) * $signed(n1_up[2]);
    t1_p_r[4] <= $signed(n1_vec[0]) * $signed(n1_up[1]);
    t1_p_r[5] <= $signed(n1_vec[1]) * $signed(n1_up[0]);
    t1_f_r    <= n1_vec;
    t1_eye_r  <= n1_eye;
    t1_z_r    <= n1_flag.zero;
  end

  logic               t2_v_r;
  logic [2:0][CW-1:0] t2_c_r;
  logic [2:0][FW-1:0] t2_f_r;
  logic [2:0][WW-1:0] t2_eye_r;
  logic               t2_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_v_r <= 1'b0;
    end else begin
      t2_v_r <= t1_v_r;
    end
    for (int i = 0; i < 3; i++) begin
      t2_c_r[i] <= {t1_p_r[2*i][PW-1], t1_p_r[2*i]}
                 - {t1_p_r[2*i+1][PW-1], t1_p_r[2*i+1]};
    end
    t2_f_r   <= t1_f_r;
    t2_eye_r <= t1_eye_r;
    t2_z_r   <= t1_z_r;
  end

  // side vector
  lav_pkg::nrm_flag_t n2_flag;
  logic [2:0][FW-1:0] n2_vec;
  logic [SB2_W-1:0]   n2_sb;

  lav_norm #(
    .IN_W      (CW),
    .FRAC_BITS (FRAC_BITS),
    .SB_W      (SB2_W)
  ) u_norm_s (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (t2_v_r),
    .in_vec   (t2_c_r),
    .in_sb    ({t2_eye_r, t2_f_r, t2_z_r}),
    .out_flag (n2_flag),
    .out_vec  (n2_vec),
    .out_sb   (n2_sb)
  );

  logic [2:0][WW-1:0] n2_eye;
  logic [2:0][FW-1:0] n2_f;

  assign n2_eye = n2_sb[SB2_W-1:3*FW+1];
  assign n2_f   = n2_sb[3*FW:1];

  // s x f and dot products
  logic                 t3_v_r;
  logic signed [SW-1:0] t3_sf_r [6];
  logic signed [PW-1:0] t3_se_r [3];
  logic signed [PW-1:0] t3_fe_r [3];
  logic [2:0][FW-1:0]   t3_s_r;
  logic [2:0][FW-1:0]   t3_f_r;
  logic [2:0][WW-1:0]   t3_eye_r;
  logic                 t3_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t3_v_r <= 1'b0;
    end else begin
      t3_v_r <= n2_flag.valid;
    end
    t3_sf_r[0] <= $signed(n2_vec[1]) * $signed(n2_f[2]);
    t3_sf_r[1] <= $signed(n2_vec[2]) * $signed(n2_f[1]);
    t3_sf_r[2] <= $signed(n2_vec[2]) * $signed(n2_f[0]);
    t3_sf_r[3] <= $signed(n2_vec[0]) * $signed(n2_f[2]);
    t3_sf_r[4] <= $signed(n2_vec[0]) * $signed(n2_f[1]);
    t3_sf_r[5] <= $signed(n2_vec[1]) * $signed(n2_f[0]);
    for (int i = 0; i < 3; i++) begin
      t3_se_r[i] <= $signed(n2_vec[i]) * $signed(n2_eye[i]);
      t3_fe_r[i] <= $signed(n2_f[i]) * $signed(n2_eye[i]);
    end
    t3_s_r   <= n2_vec;
    t3_f_r   <= n2_f;
    t3_eye_r <= n2_eye;
    t3_dg_r  <= n2_sb[0] | n2_flag.zero;
  end

  logic                  t4_v_r;
  logic signed [UFW-1:0] t4_uf_r [3];
  logic signed [DW-1:0]  t4_sd_r;
  logic signed [DW-1:0]  t4_fd_r;
  logic [2:0][FW-1:0]    t4_s_r;
  logic [2:0][FW-1:0]    t4_f_r;
  logic [2:0][WW-1:0]    t4_eye_r;
  logic                  t4_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t4_v_r <= 1'b0;
    end else begin
      t4_v_r <= t3_v_r;
    end
    for (int i = 0; i < 3; i++) begin
      t4_uf_r[i] <= UFW'(t3_sf_r[2*i]) - UFW'(t3_sf_r[2*i+1]);
    end
    t4_sd_r  <= DW'(t3_se_r[0]) + DW'(t3_se_r[1]) + DW'(t3_se_r[2]);
    t4_fd_r  <= DW'(t3_fe_r[0]) + DW'(t3_fe_r[1]) + DW'(t3_fe_r[2]);
    t4_s_r   <= t3_s_r;
    t4_f_r   <= t3_f_r;
    t4_eye_r <= t3_eye_r;
    t4_dg_r  <= t3_dg_r;
  end

  // true up vector, translation rows 0 and 2
  logic               t5_v_r;
  logic [2:0][UW-1:0] t5_u_r;
  logic signed [31:0] t5_c0_r;
  logic signed [31:0] t5_c2_r;
  logic [2:0][FW-1:0] t5_s_r;
  logic [2:0][FW-1:0] t5_f_r;
  logic [2:0][WW-1:0] t5_eye_r;
  logic               t5_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t5_v_r <= 1'b0;
    end else begin
      t5_v_r <= t4_v_r;
    end
    for (int i = 0; i < 3; i++) begin
      t5_u_r[i] <= UW'(rnd_down(64'(t4_uf_r[i])));
    end
    t5_c0_r  <= sat32(rnd_down(-64'(t4_sd_r)));
    t5_c2_r  <= sat32(rnd_down(64'(t4_fd_r)));
    t5_s_r   <= t4_s_r;
    t5_f_r   <= t4_f_r;
    t5_eye_r <= t4_eye_r;
    t5_dg_r  <= t4_dg_r;
  end

  logic                  t6_v_r;
  logic signed [UPW-1:0] t6_ue_r [3];
  logic [2:0][UW-1:0]    t6_u_r;
  logic signed [31:0]    t6_c0_r;
  logic signed [31:0]    t6_c2_r;
  logic [2:0][FW-1:0]    t6_s_r;
  logic [2:0][FW-1:0]    t6_f_r;
  logic                  t6_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t6_v_r <= 1'b0;
    end else begin
      t6_v_r <= t5_v_r;
    end
    for (int i = 0; i < 3; i++) begin
      t6_ue_r[i] <= $signed(t5_u_r[i]) * $signed(t5_eye_r[i]);
    end
    t6_u_r  <= t5_u_r;
    t6_c0_r <= t5_c0_r;
    t6_c2_r <= t5_c2_r;
    t6_s_r  <= t5_s_r;
    t6_f_r  <= t5_f_r;
    t6_dg_r <= t5_dg_r;
  end

  logic                  t7_v_r;
  logic signed [UDW-1:0] t7_ud_r;
  logic [2:0][UW-1:0]    t7_u_r;
  logic signed [31:0]    t7_c0_r;
  logic signed [31:0]    t7_c2_r;
  logic [2:0][FW-1:0]    t7_s_r;
  logic [2:0][FW-1:0]    t7_f_r;
  logic                  t7_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t7_v_r <= 1'b0;
    end else begin
      t7_v_r <= t6_v_r;
    end
    t7_ud_r <= UDW'(t6_ue_r[0]) + UDW'(t6_ue_r[1]) + UDW'(t6_ue_r[2]);
    t7_u_r  <= t6_u_r;
    t7_c0_r <= t6_c0_r;
    t7_c2_r <= t6_c2_r;
    t7_s_r  <= t6_s_r;
    t7_f_r  <= t6_f_r;
    t7_dg_r <= t6_dg_r;
  end

  // matrix hold register, loaded once per request and held for its columns
  logic                  mat_v_r;
  logic [2:0][31:0]      mat_e0_r;
  logic [2:0][31:0]      mat_e1_r;
  logic [2:0][31:0]      mat_e2_r;
  logic [2:0][31:0]      mat_c3_r;
  logic                  mat_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_v_r <= 1'b0;
    end else begin
      mat_v_r <= t7_v_r;
    end
    if (t7_v_r) begin
      for (int i = 0; i < 3; i++) begin
        mat_e0_r[i] <= 32'($signed(t7_s_r[i]));
        mat_e1_r[i] <= 32'($signed(t7_u_r[i]));
        mat_e2_r[i] <= 32'(-$signed(t7_f_r[i]));
      end
      mat_c3_r[0] <= t7_c0_r;
      mat_c3_r[1] <= sat32(rnd_down(-64'(t7_ud_r)));
      mat_c3_r[2] <= t7_c2_r;
      mat_dg_r    <= t7_dg_r;
    end
  end

  // column sequencer
  logic          act_r;
  lav_pkg::col_t cnt_r;
  lav_pkg::col_t col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= lav_pkg::COL_FIRST;
    end else if (mat_v_r) begin
      act_r <= 1'b1;
      cnt_r <= lav_pkg::COL_FIRST + 2'd1;
    end else if (act_r) begin
      if (cnt_r == lav_pkg::COL_LAST) begin
        act_r <= 1'b0;
      end
      cnt_r <= cnt_r + 2'd1;
    end
  end

  assign col            = mat_v_r ? lav_pkg::COL_FIRST : cnt_r;
  assign out_valid      = mat_v_r || act_r;
  assign out_column     = col;
  assign out_degenerate = mat_dg_r;
  assign out_last       = (col == lav_pkg::COL_LAST);

  always_comb begin
    case (col)
      2'd0, 2'd1, 2'd2: begin
        out_entry_0 = mat_e0_r[col];
        out_entry_1 = mat_e1_r[col];
        out_entry_2 = mat_e2_r[col];
        out_entry_3 = '0;
      end
      default: begin
        out_entry_0 = mat_c3_r[0];
        out_entry_1 = mat_c3_r[1];
        out_entry_2 = mat_c3_r[2];
        out_entry_3 = 32'(64'sd1 <<< FRAC_BITS);
      end
    endcase
  end

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> busy)
    else $error("busy not raised after request");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mat_v_r |-> !act_r)
    else $error("new matrix while columns still going out");

  a_cols_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> (out_valid && out_column == $past(out_column) + 2'd1))
    else $error("column sequence broken");

  a_first_col: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid)) |-> out_column == lav_pkg::COL_FIRST)
    else $error("result burst does not open on column 0");

endmodule
`default_nettype wire
